// ===== src/lzw_pkg.sv =====
package lzw_pkg;

    localparam int BYTE_BITS  = 8;
    // generation tag kept in every hash slot; a slot counts only under the current tag
    localparam int EPOCH_BITS = 4;
    localparam int FIRST_FREE = 256;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CMP,
        S_MISS,
        S_FLUSH,
        S_MARK
    } t_state;

    typedef struct packed {
        logic hit;
        logic empty;
    } t_probe;

endpackage

// ===== src/lzw_hash_ram.sv =====
module lzw_hash_ram #(
    parameter int ADDR_BITS = 13,
    parameter int DATA_BITS = 36
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [1 << ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lzw_probe.sv =====
module lzw_probe #(
    parameter int CODE_BITS = 12
) (
    input  logic [lzw_pkg::EPOCH_BITS+2*CODE_BITS+lzw_pkg::BYTE_BITS-1:0] i_slot,
    input  logic [CODE_BITS+lzw_pkg::BYTE_BITS-1:0]                       i_key,
    input  logic [lzw_pkg::EPOCH_BITS-1:0]                                i_epoch,
    output lzw_pkg::t_probe                                               o_res,
    output logic [CODE_BITS-1:0]                                          o_code
);

    import lzw_pkg::*;

    localparam int KEY_BITS = CODE_BITS + BYTE_BITS;

    logic [EPOCH_BITS-1:0] slot_epoch;
    logic [KEY_BITS-1:0]   slot_key;

    // slot layout, high to low: epoch, key, code
    assign slot_epoch = i_slot[EPOCH_BITS+KEY_BITS+CODE_BITS-1:KEY_BITS+CODE_BITS];
    assign slot_key   = i_slot[KEY_BITS+CODE_BITS-1:CODE_BITS];
    assign o_code     = i_slot[CODE_BITS-1:0];

    always_comb begin
        o_res.empty = (slot_epoch != i_epoch);
        o_res.hit   = !o_res.empty && (slot_key == i_key);
    end

endmodule

// ===== src/lzw_compressor_12bit.sv =====
// LZW compressor with fixed-width codes. Feed raw bytes on the input stream
// (tuser low) and mark end of file with one item carrying tuser high; the
// block emits CODE_BITS-wide codes, then the end marker (all ones) with tlast
// set, and starts the next file on a fresh dictionary. The dictionary lives in
// a 2^(CODE_BITS+1)-slot hash table with linear probing, one write and one read
// port, registered read; a single compare unit checks one slot per probe. Each
// probe of a collision chain reads a slot, then compares it; a miss emits the
// prefix and inserts once the output is free. End of file flushes any held
// prefix, then the marker, each once the output is free. The input is not
// ready while a byte is being searched. After reset, and once every 15
// dictionary restarts when the slot generation tag wraps, a clearing pass
// sweeps all 2^(CODE_BITS+1) slots (8192 at the default), input held off.
module lzw_compressor_12bit #(
    parameter int CODE_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input stream
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [lzw_pkg::BYTE_BITS-1:0]         i_s_tdata,  // [7:0] data_byte
    input  logic                                  i_s_tuser,  // [0] func
    // output stream
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [((CODE_BITS+7)/8)*8-1:0]        o_m_tdata,  // [CODE_BITS-1:0] code, rest 0
    output logic                                  o_m_tlast   // last
);

    import lzw_pkg::*;

    localparam int IDX_BITS  = CODE_BITS + 1;
    localparam int KEY_BITS  = CODE_BITS + BYTE_BITS;
    localparam int SLOT_BITS = EPOCH_BITS + KEY_BITS + CODE_BITS;
    localparam int OUT_BITS  = ((CODE_BITS + 7) / 8) * 8;

    localparam logic [CODE_BITS-1:0]  END_MARK  = '1;
    localparam logic [CODE_BITS-1:0]  FREE_BASE = CODE_BITS'(FIRST_FREE);
    localparam logic [EPOCH_BITS-1:0] EPOCH_ONE = EPOCH_BITS'(1);

    // sequencer state
    t_state                 r_state, n_state;

    // compressor state
    logic [CODE_BITS-1:0]   r_prefix;
    logic                   r_pvalid;
    logic [CODE_BITS-1:0]   r_next;
    logic [EPOCH_BITS-1:0]  r_epoch;
    logic [BYTE_BITS-1:0]   r_byte;
    logic [IDX_BITS-1:0]    r_addr;
    logic [IDX_BITS-1:0]    r_clr;

    // output register
    logic                   r_out_valid;
    logic [CODE_BITS-1:0]   r_out_code;
    logic                   r_out_last;

    // control
    logic                   accept;
    logic                   out_free;
    logic                   ld_out;
    logic [CODE_BITS-1:0]   ld_code;
    logic                   ld_last;
    logic                   do_miss;
    logic                   restart;
    logic                   epoch_wrap;
    logic                   mem_we;
    logic [IDX_BITS-1:0]    mem_waddr;
    logic [SLOT_BITS-1:0]   mem_wdata;
    logic [SLOT_BITS-1:0]   mem_rdata;
    logic [KEY_BITS-1:0]    key;
    logic [IDX_BITS-1:0]    hash;
    t_probe                 probe;
    logic [CODE_BITS-1:0]   probe_code;

    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign key        = {r_prefix, r_byte};
    assign epoch_wrap = &r_epoch;
    // fold the incoming byte onto the top of the prefix code
    assign hash = IDX_BITS'(r_prefix) ^ (IDX_BITS'(i_s_tdata) << (IDX_BITS - BYTE_BITS));

    lzw_hash_ram #(
        .ADDR_BITS (IDX_BITS),
        .DATA_BITS (SLOT_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    lzw_probe #(
        .CODE_BITS (CODE_BITS)
    ) u_probe (
        .i_slot  (mem_rdata),
        .i_key   (key),
        .i_epoch (r_epoch),
        .o_res   (probe),
        .o_code  (probe_code)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (&r_clr) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_s_tuser == FUNC_END) begin
                        n_state = r_pvalid ? S_FLUSH : S_MARK;
                    end else if (r_pvalid) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: n_state = S_CMP;
            S_CMP: begin
                priority if (probe.hit) n_state = S_IDLE;
                else if (probe.empty)   n_state = S_MISS;
                else                    n_state = S_READ;
            end
            S_MISS: begin
                if (out_free) n_state = (restart && epoch_wrap) ? S_CLEAR : S_IDLE;
            end
            S_FLUSH: begin
                if (out_free) n_state = S_MARK;
            end
            S_MARK: begin
                if (out_free) n_state = epoch_wrap ? S_CLEAR : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_tready = 1'b0;
        ld_out     = 1'b0;
        ld_code    = r_prefix;
        ld_last    = 1'b0;
        do_miss    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_addr;
        mem_wdata  = {r_epoch, key, r_next};
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_IDLE:  o_s_tready = 1'b1;
            S_READ, S_CMP: begin
            end
            S_MISS: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    do_miss = 1'b1;
                    mem_we  = 1'b1;
                end
            end
            S_FLUSH: ld_out = out_free;
            S_MARK: begin
                ld_out  = out_free;
                ld_code = END_MARK;
                ld_last = 1'b1;
            end
            default: begin
            end
        endcase
        // dictionary restarts after end of file or once the last code below the marker is taken
        restart = ((r_state == S_MARK) && out_free)
                  || (do_miss && (r_next == END_MARK - CODE_BITS'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_prefix <= '0;
            r_pvalid <= 1'b0;
            r_next   <= FREE_BASE;
            r_epoch  <= EPOCH_ONE;
            r_clr    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            // first byte of a file just becomes the prefix
            if (accept && (i_s_tuser == FUNC_DATA) && !r_pvalid) begin
                r_prefix <= CODE_BITS'(i_s_tdata);
                r_pvalid <= 1'b1;
            end
            if ((r_state == S_CMP) && probe.hit) begin
                r_prefix <= probe_code;
            end
            if (do_miss) begin
                r_prefix <= CODE_BITS'(r_byte);
                r_next   <= r_next + 1'b1;
            end
            if (restart) begin
                r_next  <= FREE_BASE;
                r_epoch <= epoch_wrap ? EPOCH_ONE : r_epoch + 1'b1;
                if (r_state == S_MARK) begin
                    r_prefix <= '0;
                    r_pvalid <= 1'b0;
                end
            end
        end
    end

    // payload: byte under search and probe address
    always_ff @(posedge i_clk) begin
        if (accept && (i_s_tuser == FUNC_DATA)) begin
            r_byte <= i_s_tdata;
            r_addr <= hash;
        end else if ((r_state == S_CMP) && !probe.hit && !probe.empty) begin
            r_addr <= r_addr + 1'b1;
        end
    end

    // output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_code <= ld_code;
            r_out_last <= ld_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_BITS'(r_out_code);
    assign o_m_tlast  = r_out_last;

endmodule

// ===== src/lzw_check.sv =====
module lzw_check #(
    parameter int CODE_BITS = 12
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           i_s_tuser,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [((CODE_BITS+7)/8)*8-1:0] o_m_tdata,
    input logic                           o_m_tlast
);

    localparam logic [CODE_BITS-1:0] END_MARK = '1;

    // last is only ever set on the end marker
    a_mark_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[CODE_BITS-1:0] == END_MARK)
        else $error("last set on a code other than the end marker");

    // no ordinary code reaches the marker value
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata[CODE_BITS-1:0] != END_MARK)
        else $error("data code collides with the end marker");

    // end of file keeps the input held off for the flush
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser |=> !o_s_tready)
        else $error("input ready right after end of file");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output changed while stalled");

endmodule

bind lzw_compressor_12bit lzw_check #(
    .CODE_BITS (CODE_BITS)
) u_lzw_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// ===== dv/lzw_compressor_12bit_test.sv =====
module lzw_compressor_12bit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lzw_pkg::*;

    localparam int CODE_BITS = 12;
    localparam int TDATA_W = ((CODE_BITS + 7) / 8) * 8;
    localparam logic [CODE_BITS-1:0] END_CODE = '1;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 800;
    localparam int FILL_LENGTH = 300;

    // Byte source patterns for one random file.
    typedef enum int {
        KIND_NARROW,
        KIND_RUNS,
        KIND_RANDOM
    } file_kind_t;

    typedef struct packed {
        logic                 func;
        logic [BYTE_BITS-1:0] data_byte;
        logic                 hold_off;   // wait for every pending code before sending
    } byte_item_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic                 last;
    } code_item_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [BYTE_BITS-1:0] i_s_tdata = '0;    // [7:0] data_byte
    logic                 i_s_tuser = FUNC_DATA;  // [0] func
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [TDATA_W-1:0]   o_m_tdata;         // [11:0] code, rest 0
    logic                 o_m_tlast;         // last

    byte_item_t pending_bytes[$];
    code_item_t expected_codes[$];

    // Shadow of the compressor state.
    logic [CODE_BITS-1:0] cur_prefix = '0;
    logic                 prefix_held = 1'b0;
    int                   free_code = FIRST_FREE;
    logic [CODE_BITS-1:0] pair_codes [int];   // {prefix, byte} -> dictionary code

    logic codes_outstanding = 1'b0;
    int   src_gap = 0;
    logic src_burst = 1'b0;
    int   snk_stall = 0;
    logic snk_burst = 1'b0;

    int cycle_count = 0;
    int fail_count = 0;
    int bytes_taken = 0;
    int codes_checked = 0;
    int files_closed = 0;
    int dict_wraps = 0;

    lzw_compressor_12bit #(
        .CODE_BITS(CODE_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    always #6 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one; none at all during a burst.
    function automatic int draw_gap(input logic burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Append one expected code to the scoreboard.
    function automatic void expect_code(input logic [CODE_BITS-1:0] c, input logic l);
        code_item_t item;
        item = '{code: c, last: l};
        expected_codes.insert(expected_codes.size(), item);
    endfunction

    // Advance the shadow compressor by one accepted item and queue its codes.
    function automatic void compress_item(input logic func, input logic [BYTE_BITS-1:0] din);
        int key;
        key = int'({cur_prefix, din});
        if (func == FUNC_END) begin
            // flush the held prefix, then the end marker; next file starts fresh
            if (prefix_held) expect_code(cur_prefix, 1'b0);
            expect_code(END_CODE, 1'b1);
            cur_prefix = '0;
            prefix_held = 1'b0;
            free_code = FIRST_FREE;
            pair_codes.delete();
            files_closed++;
        end else if (!prefix_held) begin
            // first byte of a file only opens the prefix
            cur_prefix = CODE_BITS'(din);
            prefix_held = 1'b1;
        end else if (pair_codes.exists(key)) begin
            cur_prefix = pair_codes[key];
        end else begin
            expect_code(cur_prefix, 1'b0);
            pair_codes[key] = CODE_BITS'(free_code);
            free_code++;
            cur_prefix = CODE_BITS'(din);
            // the dictionary falls back to the single bytes once the marker code is reached
            if (free_code >= int'(END_CODE)) begin
                free_code = FIRST_FREE;
                pair_codes.delete();
                dict_wraps++;
            end
        end
    endfunction

    function automatic void add_item(input logic func, input logic [BYTE_BITS-1:0] b,
                                     input logic hold);
        byte_item_t item;
        item = '{func: func, data_byte: b, hold_off: hold};
        pending_bytes.insert(pending_bytes.size(), item);
    endfunction

    // Queue one file of len bytes followed by its end item.
    function automatic void queue_file(input int len, input file_kind_t kind, input logic hold);
        logic [BYTE_BITS-1:0] sym [4];
        logic [BYTE_BITS-1:0] b;
        int nsym;
        for (int k = 0; k < 4; k++) sym[k] = BYTE_BITS'($urandom_range(0, 255));
        nsym = $urandom_range(1, 4);
        b = sym[0];
        for (int i = 0; i < len; i++) begin
            case (kind)
                KIND_NARROW: b = sym[$urandom_range(0, nsym - 1)];
                KIND_RUNS: begin
                    if ($urandom_range(0, 3) == 0) b = BYTE_BITS'($urandom_range(0, 255));
                end
                default: b = BYTE_BITS'($urandom_range(0, 255));
            endcase
            add_item(FUNC_DATA, b, hold && i == 0);
        end
        add_item(FUNC_END, BYTE_BITS'($urandom_range(0, 255)), hold && len == 0);
    endfunction

    // Byte driver: present the next pending item, hold it until taken, idle at random.
    always @(posedge i_clk) begin : byte_driver
        logic present;
        logic just_taken;
        byte_item_t nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_s_tuser  <= FUNC_DATA;
            src_gap = 0;
        end else begin
            just_taken = i_s_tvalid && o_s_tready;
            present = i_s_tvalid && !o_s_tready;
            if ($urandom_range(0, 199) == 0) src_burst = !src_burst;
            if (!present) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_bytes.size() != 0 &&
                             !(pending_bytes[0].hold_off && (codes_outstanding || just_taken))) begin
                    nxt = pending_bytes.pop_front();
                    present = 1'b1;
                    i_s_tdata <= nxt.data_byte;
                    i_s_tuser <= nxt.func;
                    src_gap = draw_gap(src_burst);
                end
            end
            i_s_tvalid <= present;
        end
    end

    // Code monitor: check accepted codes, predict from accepted bytes, stall the output.
    always @(posedge i_clk) begin : code_monitor
        code_item_t want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            codes_outstanding <= 1'b0;
            snk_stall = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_codes.size() == 0) begin
                    $display("%0t: unexpected code, expected none, got %0d (last %0b)",
                             $time, o_m_tdata, o_m_tlast);
                    fail_count++;
                end else begin
                    want = expected_codes.pop_front();
                    if (o_m_tdata !== TDATA_W'(want.code)) begin
                        $display("%0t: code mismatch, expected %0d, got %0d",
                                 $time, want.code, o_m_tdata);
                        fail_count++;
                    end
                    if (o_m_tlast !== want.last) begin
                        $display("%0t: tlast mismatch on code %0d, expected %0b, got %0b",
                                 $time, want.code, want.last, o_m_tlast);
                        fail_count++;
                    end
                    codes_checked++;
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                compress_item(i_s_tuser, i_s_tdata);
                bytes_taken++;
            end
            codes_outstanding <= (expected_codes.size() != 0);
            if ($urandom_range(0, 199) == 0) snk_burst = !snk_burst;
            if (snk_stall > 0) begin
                snk_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                snk_stall = draw_gap(snk_burst);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d items unsent, %0d codes pending",
                     $time, cycle_count, pending_bytes.size(), expected_codes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int random_items;
        int len;
        int r;
        int file_idx;
        file_kind_t kind;

        // end of file with no prefix held: marker alone
        add_item(FUNC_END, 8'h00, 1'b0);
        // first byte opens the prefix; extreme byte values; the end item's byte is ignored
        add_item(FUNC_DATA, 8'h00, 1'b0);
        add_item(FUNC_DATA, 8'hFF, 1'b0);
        add_item(FUNC_DATA, 8'hFF, 1'b0);
        add_item(FUNC_DATA, 8'h00, 1'b0);
        add_item(FUNC_END, 8'hA5, 1'b0);
        // repeated byte: the prefix grows through dictionary hits
        repeat (5) add_item(FUNC_DATA, 8'h41, 1'b0);
        add_item(FUNC_END, 8'hFF, 1'b0);
        // back-to-back end items
        add_item(FUNC_END, 8'h5A, 1'b0);
        // alternating bit patterns
        for (int i = 0; i < 6; i++) add_item(FUNC_DATA, (i % 2) ? 8'hAA : 8'h55, 1'b0);
        add_item(FUNC_END, 8'h00, 1'b0);

        random_items = 0;
        file_idx = 0;
        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 8) len = 0;
            else if (r < 80) len = $urandom_range(1, 40);
            else len = $urandom_range(41, 160);
            kind = file_kind_t'($urandom_range(0, 2));
            // pause the source until all codes are back every eighth file
            queue_file(len, kind, file_idx % 8 == 7);
            random_items += len + 1;
            file_idx++;
        end
        // one long file of random bytes grows a large dictionary
        queue_file(FILL_LENGTH, KIND_RANDOM, 1'b1);
        for (int i = 0; i < 4; i++) queue_file($urandom_range(0, 30), KIND_NARROW, 1'b0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample away from the clock edge so the queues have settled
        while (pending_bytes.size() != 0 || i_s_tvalid || expected_codes.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (expected_codes.size() != 0) begin
            $display("%0t: %0d codes never arrived, next expected %0d, got none",
                     $time, expected_codes.size(), expected_codes[0].code);
        end
        $display("Sent %0d items over %0d files; checked %0d codes; %0d dictionary wraps.",
                 bytes_taken, files_closed, codes_checked, dict_wraps);
        $display("Random stalls on both streams, bursts without gaps, source held to drain.");
        if (fail_count == 0 && expected_codes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== lzw_compressor_12bit.f =====
src/lzw_pkg.sv
src/lzw_hash_ram.sv
src/lzw_probe.sv
src/lzw_compressor_12bit.sv
src/lzw_check.sv
dv/lzw_compressor_12bit_test.sv
